### src/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants, types and divider step functions of the block region
// aligner.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int BLOCK_BITS = 64;
    localparam int GRAIN_W    = 64;
    localparam int BS_W       = 17;
    localparam int CFG_W      = 32;
    localparam int OFF_W      = 32;
    localparam int IDX_W      = 3;
    localparam int MODE_W     = 2;
    localparam int CNT_W      = $clog2(GRAIN_W);
    localparam int SHIFT_W    = $clog2(GRAIN_W) + 1;

    localparam logic [CFG_W-1:0] MIN_GRAIN_RESET = CFG_W'(1048576);

    typedef enum logic [IDX_W-1:0] {
        REG_OPT_MODE  = IDX_W'(0),
        REG_OPT_IO    = IDX_W'(1),
        REG_MIN_GRAIN = IDX_W'(2),
        REG_EXTRA     = IDX_W'(3),
        REG_OFFSET    = IDX_W'(4)
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALIGN_BOTH = MODE_W'(0),
        MODE_KEEP_END   = MODE_W'(1),
        MODE_KEEP_SIZE  = MODE_W'(2),
        MODE_ALIGN_END  = MODE_W'(3)
    } t_mode;

    typedef enum logic [2:0] {
        G_IDLE,
        G_INIT,
        G_DOUBLE,
        G_EXTRA,
        G_TWOS,
        G_GCD,
        G_DIV,
        G_MUL
    } t_gstate;

    // Grain unit to datapath.
    typedef struct packed {
        logic                    busy;
        logic [GRAIN_W-1:0]      grain;
        logic signed [OFF_W-1:0] offset;
    } t_grain_if;

    // Item while the grain in blocks and the offset in blocks are divided out.
    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [BLOCK_BITS-1:0] start;
        logic [BLOCK_BITS-1:0] endv;
        logic [BLOCK_BITS-1:0] endp1;
        logic [BLOCK_BITS-1:0] len;
        logic [BS_W-1:0]       bs;
        logic [GRAIN_W-1:0]    gdiv;
        logic [BS_W-1:0]       grem;
        logic [OFF_W-1:0]      odiv;
        logic [BS_W-1:0]       orem;
        logic                  oneg;
    } t_div_item;

    // Item while start and end are reduced modulo the grain.
    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [BLOCK_BITS-1:0] start;
        logic [BLOCK_BITS-1:0] endv;
        logic [BLOCK_BITS-1:0] len;
        logic                  bs_zero;
        logic [GRAIN_W-1:0]    gb;
        logic [BLOCK_BITS-1:0] be;
        logic [BLOCK_BITS-1:0] sd;
        logic [BLOCK_BITS-1:0] ed;
        logic [GRAIN_W-1:0]    rs;
        logic [GRAIN_W-1:0]    re;
    } t_mod_item;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [BLOCK_BITS-1:0] start;
        logic [BLOCK_BITS-1:0] len;
        logic                  bs_zero;
        logic [BLOCK_BITS-1:0] pad;
        logic [BLOCK_BITS-1:0] endn;
        logic                  efail;
    } t_fin1;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [BLOCK_BITS-1:0] len;
        logic                  bs_zero;
        logic [BLOCK_BITS-1:0] pad;
        logic [BLOCK_BITS-1:0] sn;
        logic [BLOCK_BITS-1:0] endn;
        logic                  efail;
    } t_fin2;

    // One restoring division step with a block size divisor: {quotient bit, remainder}.
    function automatic logic [BS_W:0] div_step_bs(input logic [BS_W-1:0] rem,
                                                  input logic din,
                                                  input logic [BS_W-1:0] d);
        logic [BS_W:0] t;
        logic [BS_W:0] t2;
        t  = {rem, din};
        t2 = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, t2[BS_W-1:0]};
        end
        return {1'b0, t[BS_W-1:0]};
    endfunction

    // One restoring division step with a grain wide divisor.
    function automatic logic [GRAIN_W:0] div_step_g(input logic [GRAIN_W-1:0] rem,
                                                   input logic din,
                                                   input logic [GRAIN_W-1:0] d);
        logic [GRAIN_W:0] t;
        logic [GRAIN_W:0] t2;
        t  = {rem, din};
        t2 = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, t2[GRAIN_W-1:0]};
        end
        return {1'b0, t[GRAIN_W-1:0]};
    endfunction

endpackage

### src/bra_grain.sv
// ----------------------------------------------------------------------------
// bra_grain
// Configuration registers and the sequential unit that derives the grain in
// bytes (doubling, binary gcd, serial divide, serial multiply).
// ----------------------------------------------------------------------------
module bra_grain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bra_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [bra_pkg::CFG_W-1:0]  i_cfg_wdata,
    output bra_pkg::t_grain_if         o_gif
);
    import bra_pkg::*;

    logic                    r_opt;
    logic [CFG_W-1:0]        r_oio;
    logic [CFG_W-1:0]        r_min;
    logic [CFG_W-1:0]        r_extra;
    logic signed [OFF_W-1:0] r_off;

    t_gstate            r_state, n_state;
    logic [GRAIN_W-1:0] r_g, n_g;
    logic [GRAIN_W-1:0] r_a, n_a;
    logic [GRAIN_W-1:0] r_b, n_b;
    logic [SHIFT_W-1:0] r_k, n_k;
    logic [GRAIN_W-1:0] r_d, n_d;
    logic [GRAIN_W-1:0] r_q, n_q;
    logic [GRAIN_W-1:0] r_rem, n_rem;
    logic [GRAIN_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [GRAIN_W-1:0] r_grain, n_grain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt   <= 1'b0;
            r_oio   <= '0;
            r_min   <= MIN_GRAIN_RESET;
            r_extra <= '0;
            r_off   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_OPT_MODE:  r_opt   <= i_cfg_wdata[0];
                REG_OPT_IO:    r_oio   <= i_cfg_wdata;
                REG_MIN_GRAIN: r_min   <= i_cfg_wdata;
                REG_EXTRA:     r_extra <= i_cfg_wdata;
                REG_OFFSET:    r_off   <= signed'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [GRAIN_W:0] step;
        logic [GRAIN_W-1:0] sum;
        n_state = r_state;
        n_g     = r_g;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        n_d     = r_d;
        n_q     = r_q;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_grain = r_grain;
        step    = div_step_g(r_rem, r_q[GRAIN_W-1], r_d);
        sum     = r_acc + r_q;
        if (i_cfg_we) begin
            // Any write restarts the derivation with the new values.
            n_state = G_INIT;
        end else begin
            unique case (r_state)
                G_IDLE: ;
                G_INIT: begin
                    n_g     = (r_opt && r_oio != '0) ? GRAIN_W'(r_oio) : GRAIN_W'(1);
                    n_state = r_opt ? G_DOUBLE : G_EXTRA;
                end
                G_DOUBLE: begin
                    if (r_g < GRAIN_W'(r_min)) begin
                        n_g = r_g << 1;
                    end else begin
                        n_state = G_EXTRA;
                    end
                end
                G_EXTRA: begin
                    if (r_extra == '0) begin
                        n_grain = r_g;
                        n_state = G_IDLE;
                    end else begin
                        n_a     = r_g;
                        n_b     = GRAIN_W'(r_extra);
                        n_k     = '0;
                        n_state = G_TWOS;
                    end
                end
                G_TWOS: begin
                    if (!r_a[0] && !r_b[0]) begin
                        n_a = r_a >> 1;
                        n_b = r_b >> 1;
                        n_k = r_k + SHIFT_W'(1);
                    end else begin
                        n_state = G_GCD;
                    end
                end
                G_GCD: begin
                    priority if (r_b == '0) begin
                        n_d     = r_a << r_k;
                        n_q     = r_g;
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = G_DIV;
                    end else if (!r_a[0]) begin
                        n_a = r_a >> 1;
                    end else if (!r_b[0]) begin
                        n_b = r_b >> 1;
                    end else if (r_a > r_b) begin
                        n_a = r_b;
                        n_b = r_a - r_b;
                    end else begin
                        n_b = r_b - r_a;
                    end
                end
                G_DIV: begin
                    n_rem = step[GRAIN_W-1:0];
                    n_q   = {r_q[GRAIN_W-2:0], step[GRAIN_W]};
                    n_cnt = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(GRAIN_W - 1)) begin
                        n_acc   = '0;
                        n_b     = GRAIN_W'(r_extra);
                        n_cnt   = '0;
                        n_state = G_MUL;
                    end
                end
                G_MUL: begin
                    if (r_b[0]) begin
                        n_acc = sum;
                    end
                    n_q   = r_q << 1;
                    n_b   = r_b >> 1;
                    n_cnt = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(CFG_W - 1)) begin
                        n_grain = r_b[0] ? sum : r_acc;
                        n_state = G_IDLE;
                    end
                end
                default: n_state = G_IDLE;
            endcase
        end
    end

    always_comb begin
        o_gif.busy   = (r_state != G_IDLE);
        o_gif.grain  = r_grain;
        o_gif.offset = r_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_grain <= GRAIN_W'(1);
        end else begin
            r_state <= n_state;
            r_grain <= n_grain;
        end
        r_g   <= n_g;
        r_a   <= n_a;
        r_b   <= n_b;
        r_k   <= n_k;
        r_d   <= n_d;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
    end

endmodule

### src/bra_bsdiv.sv
// ----------------------------------------------------------------------------
// bra_bsdiv
// Pipelined divider by the block size: grain in blocks and offset in blocks,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module bra_bsdiv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic [bra_pkg::MODE_W-1:0]     i_mode,
    input  logic [bra_pkg::BLOCK_BITS-1:0] i_start_block,
    input  logic [bra_pkg::BLOCK_BITS-1:0] i_length_blocks,
    input  logic [bra_pkg::BS_W-1:0]       i_block_size,
    input  bra_pkg::t_grain_if             i_gif,
    output logic                           o_valid,
    output bra_pkg::t_div_item             o_item
);
    import bra_pkg::*;

    localparam int NST = GRAIN_W;

    logic      r_v  [NST+1];
    t_div_item r_it [NST+1];
    t_div_item n_it [NST+1];

    always_comb begin
        logic [OFF_W-1:0] off_u;
        logic [BS_W:0]    gs;
        logic [BS_W:0]    os;
        off_u               = unsigned'(i_gif.offset);
        n_it[0].mode        = i_mode;
        n_it[0].start       = i_start_block;
        n_it[0].len         = i_length_blocks;
        n_it[0].endv        = i_start_block + i_length_blocks - BLOCK_BITS'(1);
        n_it[0].endp1       = i_start_block + i_length_blocks;
        n_it[0].bs          = i_block_size;
        n_it[0].gdiv        = (i_gif.grain < GRAIN_W'(i_block_size)) ?
                              GRAIN_W'(i_block_size) : i_gif.grain;
        n_it[0].grem        = '0;
        n_it[0].oneg        = off_u[OFF_W-1];
        n_it[0].odiv        = off_u[OFF_W-1] ? (~off_u + OFF_W'(1)) : off_u;
        n_it[0].orem        = '0;
        for (int s = 1; s <= NST; s++) begin
            n_it[s]      = r_it[s-1];
            gs           = div_step_bs(r_it[s-1].grem, r_it[s-1].gdiv[GRAIN_W-1],
                                       r_it[s-1].bs);
            n_it[s].grem = gs[BS_W-1:0];
            n_it[s].gdiv = {r_it[s-1].gdiv[GRAIN_W-2:0], gs[BS_W]};
            os           = div_step_bs(r_it[s-1].orem, r_it[s-1].odiv[OFF_W-1],
                                       r_it[s-1].bs);
            // The offset has fewer bits, so its division ends early.
            if (s <= OFF_W) begin
                n_it[s].orem = os[BS_W-1:0];
                n_it[s].odiv = {r_it[s-1].odiv[OFF_W-2:0], os[BS_W]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= NST; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
        if (i_adv) begin
            for (int s = 0; s <= NST; s++) begin
                r_it[s] <= n_it[s];
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_item  = r_it[NST];

endmodule

### src/bra_gmod.sv
// ----------------------------------------------------------------------------
// bra_gmod
// Pipelined reduction of the start and of the end plus one, both relative to
// the offset, modulo the grain in blocks.
// ----------------------------------------------------------------------------
module bra_gmod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  bra_pkg::t_div_item i_item,
    output logic               o_valid,
    output bra_pkg::t_mod_item o_item
);
    import bra_pkg::*;

    localparam int NST = BLOCK_BITS;

    logic      r_v  [NST+1];
    t_mod_item r_it [NST+1];
    t_mod_item n_it [NST+1];

    always_comb begin
        logic [OFF_W-1:0]        qs;
        logic [BLOCK_BITS-1:0]   q;
        logic [GRAIN_W:0]        ss;
        logic [GRAIN_W:0]        es;
        qs = i_item.oneg ? (~i_item.odiv + OFF_W'(1)) : i_item.odiv;
        q  = BLOCK_BITS'(signed'(qs));
        n_it[0].mode    = i_item.mode;
        n_it[0].start   = i_item.start;
        n_it[0].endv    = i_item.endv;
        n_it[0].len     = i_item.len;
        n_it[0].bs_zero = (i_item.bs == '0);
        n_it[0].gb      = i_item.gdiv;
        n_it[0].be      = i_item.endv - q;
        n_it[0].sd      = i_item.start - q;
        n_it[0].ed      = i_item.endp1 - q;
        n_it[0].rs      = '0;
        n_it[0].re      = '0;
        for (int s = 1; s <= NST; s++) begin
            n_it[s]    = r_it[s-1];
            ss         = div_step_g(r_it[s-1].rs, r_it[s-1].sd[BLOCK_BITS-1], r_it[s-1].gb);
            es         = div_step_g(r_it[s-1].re, r_it[s-1].ed[BLOCK_BITS-1], r_it[s-1].gb);
            n_it[s].rs = ss[GRAIN_W-1:0];
            n_it[s].re = es[GRAIN_W-1:0];
            n_it[s].sd = r_it[s-1].sd << 1;
            n_it[s].ed = r_it[s-1].ed << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= NST; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
        if (i_adv) begin
            for (int s = 0; s <= NST; s++) begin
                r_it[s] <= n_it[s];
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_item  = r_it[NST];

endmodule

### src/block_region_aligner_top.sv
// ----------------------------------------------------------------------------
// block_region_aligner_top
// Aligns a region of blocks to the configured allocation grain.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while it is not stalled and returns its
// result through the entry register, 64 stages dividing by the block size,
// one offset stage, 64 stages reducing modulo the grain, two finishing stages
// and the output register. The whole pipeline holds while a result waits on
// the output. The grain in bytes is derived after every configuration write
// by a serial unit (doubling, binary gcd, serial divide, serial multiply);
// the input is stalled until it is done.
module block_region_aligner_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bra_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [bra_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bra_pkg::MODE_W-1:0]     i_mode,
    input  logic [bra_pkg::BLOCK_BITS-1:0] i_start_block,
    input  logic [bra_pkg::BLOCK_BITS-1:0] i_length_blocks,
    input  logic [bra_pkg::BS_W-1:0]       i_block_size,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bra_pkg::BLOCK_BITS-1:0] o_new_start,
    output logic [bra_pkg::BLOCK_BITS-1:0] o_new_length,
    output logic                           o_ok
);
    import bra_pkg::*;

    t_grain_if gif;
    logic      adv;
    logic      div_v;
    t_div_item div_it;
    logic      mod_v;
    t_mod_item mod_it;

    logic                  r_f1_v, r_f2_v, r_out_v;
    t_fin1                 r_f1, n_f1;
    t_fin2                 r_f2, n_f2;
    logic [BLOCK_BITS-1:0] r_start, n_start;
    logic [BLOCK_BITS-1:0] r_len, n_len;
    logic                  r_ok, n_ok;

    assign adv     = !r_out_v || !i_stall;
    assign o_stall = !adv || gif.busy;

    bra_grain u_grain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_gif       (gif)
    );

    bra_bsdiv u_bsdiv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_valid         (i_valid && !o_stall),
        .i_mode          (i_mode),
        .i_start_block   (i_start_block),
        .i_length_blocks (i_length_blocks),
        .i_block_size    (i_block_size),
        .i_gif           (gif),
        .o_valid         (div_v),
        .o_item          (div_it)
    );

    bra_gmod u_gmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (div_v),
        .i_item  (div_it),
        .o_valid (mod_v),
        .o_item  (mod_it)
    );

    // The aligned start relative to the offset plus the offset is just the
    // old start plus the pad, and likewise the aligned end is end minus r.
    always_comb begin
        n_f1.mode    = mod_it.mode;
        n_f1.start   = mod_it.start;
        n_f1.len     = mod_it.len;
        n_f1.bs_zero = mod_it.bs_zero;
        n_f1.pad     = (mod_it.rs != '0 && t_mode'(mod_it.mode) != MODE_ALIGN_END) ?
                       BLOCK_BITS'(mod_it.gb - mod_it.rs) : '0;
        n_f1.endn    = mod_it.endv - BLOCK_BITS'(mod_it.re);
        n_f1.efail   = (mod_it.re > GRAIN_W'(mod_it.be));
    end

    always_comb begin
        n_f2.mode    = r_f1.mode;
        n_f2.len     = r_f1.len;
        n_f2.bs_zero = r_f1.bs_zero;
        n_f2.pad     = r_f1.pad;
        n_f2.sn      = r_f1.start + r_f1.pad;
        n_f2.endn    = r_f1.endn;
        n_f2.efail   = r_f1.efail;
    end

    always_comb begin
        logic [BLOCK_BITS-1:0] endp1;
        endp1   = r_f2.endn + BLOCK_BITS'(1);
        n_start = r_f2.sn;
        n_len   = '0;
        n_ok    = 1'b0;
        unique case (t_mode'(r_f2.mode))
            MODE_ALIGN_BOTH, MODE_ALIGN_END: begin
                n_ok  = !r_f2.efail && (endp1 > r_f2.sn);
                n_len = endp1 - r_f2.sn;
            end
            MODE_KEEP_END: begin
                n_ok  = (r_f2.len > r_f2.pad);
                n_len = r_f2.len - r_f2.pad;
            end
            MODE_KEEP_SIZE: begin
                n_ok  = 1'b1;
                n_len = r_f2.len;
            end
            default: n_ok = 1'b0;
        endcase
        if (r_f2.bs_zero) begin
            n_ok = 1'b0;
        end
        if (!n_ok) begin
            n_start = '0;
            n_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_f1_v  <= mod_v;
            r_f2_v  <= r_f1_v;
            r_out_v <= r_f2_v;
        end
        if (adv) begin
            r_f1    <= n_f1;
            r_f2    <= n_f2;
            r_start <= n_start;
            r_len   <= n_len;
            r_ok    <= n_ok;
        end
    end

    assign o_valid      = r_out_v;
    assign o_new_start  = r_start;
    assign o_new_length = r_len;
    assign o_ok         = r_ok;

endmodule

### tb/bra_checker.sv
// ----------------------------------------------------------------------------
// bra_checker
// Watches the register port and both item channels of the block region
// aligner. It predicts each aligned region and compares it with the block.
// ----------------------------------------------------------------------------
module bra_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bra_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [bra_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [bra_pkg::MODE_W-1:0]     i_mode,
    input  logic [bra_pkg::BLOCK_BITS-1:0] i_start_block,
    input  logic [bra_pkg::BLOCK_BITS-1:0] i_length_blocks,
    input  logic [bra_pkg::BS_W-1:0]       i_block_size,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [bra_pkg::BLOCK_BITS-1:0] i_new_start,
    input  logic [bra_pkg::BLOCK_BITS-1:0] i_new_length,
    input  logic                           i_ok,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bra_pkg::*;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] start;
        logic [BLOCK_BITS-1:0] len;
        logic                  ok;
    } t_region;

    logic                    opt_mode;
    logic [CFG_W-1:0]        opt_io;
    logic [CFG_W-1:0]        min_grain;
    logic [CFG_W-1:0]        lcm_bytes;
    logic signed [OFF_W-1:0] offset_bytes;

    t_region aligned_q[$];

    function automatic logic [63:0] grain_in_bytes();
        logic [63:0] g;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        g = 64'd1;
        if (opt_mode) begin
            if (opt_io > 0) g = opt_io;
            while (g < min_grain) g = g << 1;
        end
        if (lcm_bytes != 0) begin
            a = g;
            b = lcm_bytes;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            g = (g / a) * lcm_bytes;
        end
        return g;
    endfunction

    // Rounds a start up or an end down to the grain, measured from the offset.
    function automatic logic round_to_grain(inout logic [63:0] blk, input logic [63:0] bs,
                                            input logic is_end);
        longint      qs;
        logic [63:0] q;
        logic [63:0] g;
        logic [63:0] gb;
        logic [63:0] b;
        logic [63:0] r;
        qs = longint'(offset_bytes) / longint'(bs);
        q  = qs;
        g  = grain_in_bytes();
        if (g < bs) g = bs;
        gb = g / bs;
        b  = blk - q;
        if (!is_end) begin
            r = b % gb;
            if (r != 0) b = b + (gb - r);
        end else begin
            r = (b + 64'd1) % gb;
            if (r > b) return 1'b0;
            b = b - r;
        end
        blk = b + q;
        return 1'b1;
    endfunction

    function automatic t_region align_region(input t_mode m, input logic [63:0] start0,
                                             input logic [63:0] len0, input logic [BS_W-1:0] bsz);
        t_region     res;
        logic [63:0] bs;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] delta;
        logic        good;
        bs   = bsz;
        s    = start0;
        res  = '0;
        good = (bs != 0);
        if (good && m != MODE_ALIGN_END) good = round_to_grain(s, bs, 1'b0);
        if (good) begin
            case (m)
                MODE_ALIGN_BOTH, MODE_ALIGN_END: begin
                    e    = start0 + len0 - 64'd1;
                    good = round_to_grain(e, bs, 1'b1);
                    if (good && (e + 64'd1) <= s) good = 1'b0;
                    res.len = e - s + 64'd1;
                end
                MODE_KEEP_SIZE: begin
                    res.len = len0;
                end
                default: begin
                    delta = s - start0;
                    if (len0 <= delta) good = 1'b0;
                    res.len = len0 - delta;
                end
            endcase
        end
        if (!good) return '0;
        res.start = s;
        res.ok    = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_region exp_r;
        int      popped;
        int      pushed;
        popped = 0;
        pushed = 0;
        if (!i_rst_n) begin
            opt_mode     = 1'b0;
            opt_io       = '0;
            min_grain    = MIN_GRAIN_RESET;
            lcm_bytes    = '0;
            offset_bytes = '0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_OPT_MODE:  opt_mode     = i_cfg_wdata[0];
                    REG_OPT_IO:    opt_io       = i_cfg_wdata;
                    REG_MIN_GRAIN: min_grain    = i_cfg_wdata;
                    REG_EXTRA:     lcm_bytes    = i_cfg_wdata;
                    REG_OFFSET:    offset_bytes = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                aligned_q.push_back(align_region(t_mode'(i_mode), i_start_block,
                                                 i_length_blocks, i_block_size));
                pushed = 1;
            end
            if (i_out_valid && !i_out_stall) begin
                if (aligned_q.size() == 0) begin
                    $display("%0t unexpected result start %h length %h ok %b", $time,
                             i_new_start, i_new_length, i_ok);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r  = aligned_q.pop_front();
                    popped = 1;
                    if (exp_r.start !== i_new_start || exp_r.len !== i_new_length
                            || exp_r.ok !== i_ok) begin
                        if (exp_r.start !== i_new_start)
                            $display("%0t new_start expected %h actual %h", $time,
                                     exp_r.start, i_new_start);
                        if (exp_r.len !== i_new_length)
                            $display("%0t new_length expected %h actual %h", $time,
                                     exp_r.len, i_new_length);
                        if (exp_r.ok !== i_ok)
                            $display("%0t ok expected %b actual %b", $time, exp_r.ok, i_ok);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= o_pending + pushed - popped;
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives configurations and regions into the block region aligner under
// random idling on both channels and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import bra_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 125;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [IDX_W-1:0]      i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [MODE_W-1:0]     i_mode = '0;
    logic [BLOCK_BITS-1:0] i_start_block = '0;
    logic [BLOCK_BITS-1:0] i_length_blocks = '0;
    logic [BS_W-1:0]       i_block_size = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [BLOCK_BITS-1:0] o_new_start;
    logic [BLOCK_BITS-1:0] o_new_length;
    logic                  o_ok;

    int fail_count;
    int pending;
    int cycles = 0;
    int items_sent = 0;
    int tx_idle_pct = 28;
    int rx_idle_pct = 50;

    block_region_aligner_top DUT (.*);

    bra_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_mode(i_mode), .i_start_block(i_start_block),
        .i_length_blocks(i_length_blocks), .i_block_size(i_block_size),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_new_start(o_new_start), .i_new_length(o_new_length), .i_ok(o_ok),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < rx_idle_pct);
    end

    task automatic set_idling();
        if (items_sent < 440) begin
            tx_idle_pct = 28;
            rx_idle_pct = 50;
        end else if (items_sent < 870) begin
            tx_idle_pct = 50;
            rx_idle_pct = 28;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic send_region(input t_mode m, input logic [63:0] s, input logic [63:0] l,
                               input logic [BS_W-1:0] bs);
        set_idling();
        i_valid         <= 1'b1;
        i_mode          <= m;
        i_start_block   <= s;
        i_length_blocks <= l;
        i_block_size    <= bs;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Registers change only once every region in flight has come back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic om, input logic [31:0] oio, input logic [31:0] ming,
                             input logic [31:0] extra, input logic [31:0] off);
        drain();
        write_reg(REG_OPT_MODE, {31'd0, om});
        write_reg(REG_OPT_IO, oio);
        write_reg(REG_MIN_GRAIN, ming);
        write_reg(REG_EXTRA, extra);
        write_reg(REG_OFFSET, off);
    endtask

    function automatic logic [63:0] rand_blocks();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return {32'd0, $urandom};
        if (sel < 65) return {$urandom, $urandom};
        if (sel < 80) return {32'hFFFF_FFFF, $urandom};
        return 64'($urandom_range(100));
    endfunction

    function automatic logic [BS_W-1:0] rand_block_size();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return BS_W'(1) << $urandom_range(16);
        if (sel < 85) return BS_W'($urandom_range(65536, 1));
        if (sel < 95) return BS_W'($urandom_range(8, 1));
        return BS_W'($urandom);
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Grain of one mebibyte: 2048 blocks of 512 bytes.
        configure(1'b1, 32'd0, 32'd1048576, 32'd0, 32'd0);
        send_region(MODE_ALIGN_BOTH, 64'd0, 64'd0, 17'd512);
        send_region(MODE_ALIGN_BOTH, 64'd1, 64'd4096, 17'd512);
        send_region(MODE_ALIGN_BOTH, 64'd0, 64'd2048, 17'd512);
        send_region(MODE_ALIGN_BOTH, '1, '1, 17'd512);
        send_region(MODE_KEEP_END, 64'd1, 64'd2047, 17'd512);
        send_region(MODE_KEEP_END, 64'd1, 64'd3000, 17'd512);
        send_region(MODE_KEEP_END, '1, 64'd5, 17'd512);
        send_region(MODE_KEEP_SIZE, 64'd7, 64'd0, 17'd512);
        send_region(MODE_KEEP_SIZE, '1, '1, 17'd512);
        send_region(MODE_ALIGN_END, 64'd5, 64'd10, 17'd512);
        send_region(MODE_ALIGN_END, 64'd5, 64'd5000, 17'd512);
        send_region(MODE_ALIGN_END, '1, 64'd2, 17'd512);
        send_region(MODE_ALIGN_BOTH, 64'd3, 64'd100, 17'd0);
        send_region(MODE_ALIGN_BOTH, 64'd3, 64'd100, 17'd65536);
        send_region(MODE_ALIGN_BOTH, 64'd3, 64'd100, 17'd1);
        send_region(MODE_KEEP_END, 64'd3, 64'd100, 17'h1FFFF);
        send_region(MODE_ALIGN_BOTH, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                    17'd4096);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: configure(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
                1: configure(1'b1, 32'd4096, 32'd1048576, 32'd0, 32'd2048);
                2: configure(1'b1, '1, '1, '1, 32'h8000_0000);
                3: configure(1'b0, '1, 32'd0, 32'd3000, 32'h7FFF_FFFF);
                4: configure(1'b1, 32'd65536, 32'd4096, 32'd12288, -32'sd4096);
                default: configure($urandom_range(1), $urandom_range(1 << 20),
                                   $urandom_range(1 << 22),
                                   ($urandom_range(1) ? $urandom_range(200000) : 0),
                                   $urandom);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_region(t_mode'($urandom_range(3)), rand_blocks(), rand_blocks(),
                            rand_block_size());
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
src/bra_pkg.sv
src/bra_grain.sv
src/bra_bsdiv.sv
src/bra_gmod.sv
src/block_region_aligner_top.sv
tb/bra_checker.sv
tb/tb.sv
